// ----- sv/path_point_interpolator_defines.svh -----
// ----------------------------------------------------------------------------
// Path point interpolator assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef PATH_POINT_INTERPOLATOR_DEFINES_SVH
`define PATH_POINT_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PPI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("path_point_interpolator: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("path_point_interpolator: next-cycle check failed");

`endif

// ----- sv/ppi_pkg.sv -----
// ----------------------------------------------------------------------------
// Path point interpolator package
// Widths, register indexes and the control/status types shared by the block.
// ----------------------------------------------------------------------------
package ppi_pkg;

	localparam int COORD_W = 9;
	localparam logic [COORD_W-1:0] COORD_MAX = 9'd511;

	// Shared divider: 18-bit dividend covers num*coord, 9-bit divisor
	localparam int DIV_NW  = 18;
	localparam int DIV_DW  = 9;
	localparam int DIV_CNT_W = $clog2(DIV_NW);

	// Point count per segment stays at or below 64
	localparam int PTS_W = 7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_NUM        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_DEN        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_NUM        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_DEN        = 3'd4;

	typedef struct packed {
		logic               scale_enable;
		logic [COORD_W-1:0] x_num;
		logic [COORD_W-1:0] x_den;
		logic [COORD_W-1:0] y_num;
		logic [COORD_W-1:0] y_den;
	} cfg_t;

	typedef enum logic [2:0] {
		DIV_SX  = 3'd0,
		DIV_SY  = 3'd1,
		DIV_PTS = 3'd2,
		DIV_DX  = 3'd3,
		DIV_DY  = 3'd4
	} div_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     div_start;
		div_sel_t div_start_sel;
		logic     div_store;
		div_sel_t div_store_sel;
		logic     emit_step;
		logic     emit_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scale_en;
		logic div_done;
		logic lone;
		logic pts_le1;
		logic step_final;
		logic out_free;
	} dp_status_t;

endpackage

// ----- sv/ppi_in_if.sv -----
// ----------------------------------------------------------------------------
// Waypoint input channel
// Valid/ready channel carrying one raw waypoint per transfer.
// ----------------------------------------------------------------------------
interface ppi_in_if;
	logic                        valid;
	logic                        ready;
	logic [ppi_pkg::COORD_W-1:0] point_x;
	logic [ppi_pkg::COORD_W-1:0] point_y;
	logic                        new_path;

	modport source (output valid, output point_x, output point_y, output new_path,
		input ready);
	modport sink (input valid, input point_x, input point_y, input new_path,
		output ready);
endinterface

// ----- sv/ppi_out_if.sv -----
// ----------------------------------------------------------------------------
// Path point output channel
// Valid/ready channel carrying one generated path point per transfer.
// ----------------------------------------------------------------------------
interface ppi_out_if;
	logic                        valid;
	logic                        ready;
	logic [ppi_pkg::COORD_W-1:0] out_x;
	logic [ppi_pkg::COORD_W-1:0] out_y;
	logic                        last_of_run;

	modport source (output valid, output out_x, output out_y, output last_of_run,
		input ready);
	modport sink (input valid, input out_x, input out_y, input last_of_run,
		output ready);
endinterface

// ----- sv/ppi_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ppi_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ppi_pkg::CFG_IDX_W-1:0]  index;
	logic [ppi_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/path_point_interpolator.sv -----
// ----------------------------------------------------------------------------
// Path point interpolator
// Scales waypoints and fills the gaps between them with evenly spaced points.
// ----------------------------------------------------------------------------
// Waypoints are taken one at a time; the next one is accepted once the current
// run's final point sits in the output register. Scaling and the per-axis step
// size run on one shared restoring divider that settles one quotient bit per
// cycle; the point count comes from a constant reciprocal multiply. A lone
// waypoint, or a segment too short to fill, gives its final point alone;
// scaling adds two divisions, and an interpolated segment adds the point count
// and two divisions followed by the generated points, sent while the output
// side keeps taking them. The configuration port is always ready; registers
// are meant to be written only while no run is in progress.
module path_point_interpolator #(
	parameter int STEP_DIST = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	ppi_cfg_if.sink   cfg,
	ppi_in_if.sink    point_in,
	ppi_out_if.source point_out
);
	import ppi_pkg::*;

	cfg_t       cfg_q;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_enable <= 1'b0;
			cfg_q.x_num        <= COORD_W'(1);
			cfg_q.x_den        <= COORD_W'(1);
			cfg_q.y_num        <= COORD_W'(1);
			cfg_q.y_den        <= COORD_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SCALE_ENABLE: cfg_q.scale_enable <= cfg.data[0];
				REG_X_NUM:        cfg_q.x_num        <= cfg.data;
				REG_X_DEN:        cfg_q.x_den        <= cfg.data;
				REG_Y_NUM:        cfg_q.y_num        <= cfg.data;
				REG_Y_DEN:        cfg_q.y_den        <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	ppi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (point_in.valid),
		.in_ready (point_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ppi_datapath #(
		.STEP_DIST (STEP_DIST)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.status      (status),
		.point_x     (point_in.point_x),
		.point_y     (point_in.point_y),
		.new_path    (point_in.new_path),
		.out_valid   (point_out.valid),
		.out_ready   (point_out.ready),
		.out_x       (point_out.out_x),
		.out_y       (point_out.out_y),
		.last_of_run (point_out.last_of_run)
	);

endmodule

// ----- sv/ppi_div.sv -----
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned divide, one quotient bit per cycle; done pulses when results hold.
// ----------------------------------------------------------------------------
module ppi_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ppi_pkg::DIV_NW-1:0] dividend,
	input  logic [ppi_pkg::DIV_DW-1:0] divisor,
	output logic                      done,
	output logic [ppi_pkg::DIV_NW-1:0] quotient,
	output logic [ppi_pkg::DIV_DW-1:0] remainder
);
	import ppi_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NW-1:0]    quo_q;
	logic [DIV_DW-1:0]    rem_q;
	logic [DIV_DW-1:0]    divr_q;

	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	// Shift in the next dividend bit and trial-subtract
	always_comb begin
		trial = {rem_q, quo_q[DIV_NW-1]};
		diff  = trial - {1'b0, divr_q};
		ge    = trial >= {1'b0, divr_q};
	end

	// Control: busy count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: a zero divisor yields an all-ones quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			divr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], ge};
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- sv/ppi_datapath.sv -----
// ----------------------------------------------------------------------------
// Path point interpolator datapath
// Waypoint scaling, segment setup, point stepping and the output register.
// ----------------------------------------------------------------------------
module ppi_datapath #(
	parameter int STEP_DIST = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppi_pkg::cfg_t               cfg,
	input  ppi_pkg::ctrl_cmd_t          cmd,
	output ppi_pkg::dp_status_t         status,
	input  logic [ppi_pkg::COORD_W-1:0] point_x,
	input  logic [ppi_pkg::COORD_W-1:0] point_y,
	input  logic                        new_path,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ppi_pkg::COORD_W-1:0] out_x,
	output logic [ppi_pkg::COORD_W-1:0] out_y,
	output logic                        last_of_run
);
	import ppi_pkg::*;

	// Reciprocal of the step distance, exact for every rounded span below 1024
	localparam int PTS_SH    = 20;
	localparam int PTS_RECIP = (2**PTS_SH + STEP_DIST - 1) / STEP_DIST;

	// Current waypoint and previous waypoint
	logic [COORD_W-1:0] px_q, py_q;
	logic               np_q;
	logic [COORD_W-1:0] prev_x_q, prev_y_q;
	logic               have_prev_q;

	// Segment setup
	logic [PTS_W-1:0]   pts_q;
	logic [COORD_W-1:0] qdx_q, qdy_q;
	logic [PTS_W-1:0]   rdx_q, rdy_q;

	// Stepping accumulators: floor(j*|d|/pts) and its remainder
	logic [COORD_W-1:0] accx_q, accy_q;
	logic [PTS_W-1:0]   remx_q, remy_q;
	logic [PTS_W-1:0]   j_q;

	// Output register
	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;
	logic               out_last_q;

	// Divider connection
	logic [DIV_NW-1:0] div_dividend;
	logic [DIV_DW-1:0] div_divisor;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;
	logic [DIV_DW-1:0] div_rem;

	// Differences and their magnitudes
	logic               neg_x, neg_y;
	logic [COORD_W-1:0] adx, ady, span;
	logic [COORD_W-1:0] sat_quo;

	// Point count of the segment
	logic [COORD_W:0]    span_rnd;
	logic [COORD_W+18:0] pts_prod;
	logic [PTS_W-1:0]    pts_calc;

	// Next stepping values
	logic [PTS_W:0]     sumx, sumy;
	logic               carx, cary;
	logic [PTS_W-1:0]   nremx, nremy;
	logic [COORD_W-1:0] naccx, naccy;
	logic [COORD_W-1:0] stepx, stepy;

	always_comb begin
		neg_x = px_q < prev_x_q;
		neg_y = py_q < prev_y_q;
		adx   = neg_x ? prev_x_q - px_q : px_q - prev_x_q;
		ady   = neg_y ? prev_y_q - py_q : py_q - prev_y_q;
		span  = (adx > ady) ? adx : ady;
	end

	// Round the span to the nearest step count by a constant reciprocal multiply
	always_comb begin
		span_rnd = {1'b0, span} + (COORD_W+1)'(STEP_DIST / 2);
		pts_prod = (COORD_W+19)'(span_rnd) * (COORD_W+19)'(PTS_RECIP);
		pts_calc = pts_prod[PTS_SH +: PTS_W];
	end

	// Saturate a scaled coordinate
	assign sat_quo = (div_quo > DIV_NW'(COORD_MAX)) ? COORD_MAX : div_quo[COORD_W-1:0];

	// Select divider operands for the job being started
	always_comb begin
		div_dividend = '0;
		div_divisor  = '0;
		case (cmd.div_start_sel)
			DIV_SX: begin
				div_dividend = DIV_NW'(cfg.x_num) * DIV_NW'(px_q);
				div_divisor  = DIV_DW'(cfg.x_den);
			end
			DIV_SY: begin
				div_dividend = DIV_NW'(cfg.y_num) * DIV_NW'(py_q);
				div_divisor  = DIV_DW'(cfg.y_den);
			end
			DIV_DX: begin
				div_dividend = DIV_NW'(adx);
				div_divisor  = DIV_DW'(pts_q);
			end
			DIV_DY: begin
				div_dividend = DIV_NW'(ady);
				div_divisor  = DIV_DW'(pts_q);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
			end
		endcase
	end

	ppi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Advance accumulators by one point: add quotient, carry on remainder wrap
	always_comb begin
		sumx  = {1'b0, remx_q} + {1'b0, rdx_q};
		sumy  = {1'b0, remy_q} + {1'b0, rdy_q};
		carx  = sumx >= {1'b0, pts_q};
		cary  = sumy >= {1'b0, pts_q};
		nremx = carx ? PTS_W'(sumx - {1'b0, pts_q}) : sumx[PTS_W-1:0];
		nremy = cary ? PTS_W'(sumy - {1'b0, pts_q}) : sumy[PTS_W-1:0];
		naccx = accx_q + qdx_q + COORD_W'(carx);
		naccy = accy_q + qdy_q + COORD_W'(cary);
		stepx = neg_x ? prev_x_q - naccx : prev_x_q + naccx;
		stepy = neg_y ? prev_y_q - naccy : prev_y_q + naccy;
	end

	// Waypoint capture and segment setup
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q <= point_x;
			py_q <= point_y;
			np_q <= new_path;
		end
		if (cmd.div_store) begin
			case (cmd.div_store_sel)
				DIV_SX:  px_q  <= sat_quo;
				DIV_SY:  py_q  <= sat_quo;
				DIV_PTS: pts_q <= pts_calc;
				DIV_DX: begin
					qdx_q <= div_quo[COORD_W-1:0];
					rdx_q <= div_rem[PTS_W-1:0];
				end
				DIV_DY: begin
					qdy_q  <= div_quo[COORD_W-1:0];
					rdy_q  <= div_rem[PTS_W-1:0];
					accx_q <= '0;
					accy_q <= '0;
					remx_q <= '0;
					remy_q <= '0;
					j_q    <= '0;
				end
				default: begin
				end
			endcase
		end
		if (cmd.emit_step) begin
			accx_q <= naccx;
			accy_q <= naccy;
			remx_q <= nremx;
			remy_q <= nremy;
			j_q    <= j_q + 1'b1;
		end
	end

	// Previous waypoint, updated when the run closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
		end else if (cmd.emit_last) begin
			prev_x_q    <= px_q;
			prev_y_q    <= py_q;
			have_prev_q <= 1'b1;
		end
	end

	// Output register: load a point, drop valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_step || cmd.emit_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			out_x_q    <= stepx;
			out_y_q    <= stepy;
			out_last_q <= 1'b0;
		end else if (cmd.emit_last) begin
			out_x_q    <= px_q;
			out_y_q    <= py_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign last_of_run = out_last_q;

	// Status toward the controller
	always_comb begin
		status.scale_en   = cfg.scale_enable;
		status.div_done   = div_done;
		status.lone       = np_q || !have_prev_q;
		status.pts_le1    = pts_q <= PTS_W'(1);
		status.step_final = (j_q + 1'b1) == (pts_q - 1'b1);
		status.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ----- sv/ppi_ctrl.sv -----
// ----------------------------------------------------------------------------
// Path point interpolator controller
// Sequences scaling, segment setup and point emission for one waypoint.
// ----------------------------------------------------------------------------
module ppi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ppi_pkg::dp_status_t status,
	output ppi_pkg::ctrl_cmd_t  cmd
);
	import ppi_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_PREP  = 11'b000_0000_0010,
		ST_SX    = 11'b000_0000_0100,
		ST_SY    = 11'b000_0000_1000,
		ST_ROUTE = 11'b000_0001_0000,
		ST_PTS   = 11'b000_0010_0000,
		ST_PCHK  = 11'b000_0100_0000,
		ST_DX    = 11'b000_1000_0000,
		ST_DY    = 11'b001_0000_0000,
		ST_EMIT  = 11'b010_0000_0000,
		ST_LAST  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d           = state_q;
		in_ready          = 1'b0;
		cmd.load_in       = 1'b0;
		cmd.div_start     = 1'b0;
		cmd.div_start_sel = DIV_SX;
		cmd.div_store     = 1'b0;
		cmd.div_store_sel = DIV_SX;
		cmd.emit_step     = 1'b0;
		cmd.emit_last     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				if (status.scale_en) begin
					cmd.div_start     = 1'b1;
					cmd.div_start_sel = DIV_SX;
					state_d           = ST_SX;
				end else begin
					state_d = ST_ROUTE;
				end
			end
			ST_SX: begin
				if (status.div_done) begin
					cmd.div_store     = 1'b1;
					cmd.div_store_sel = DIV_SX;
					cmd.div_start     = 1'b1;
					cmd.div_start_sel = DIV_SY;
					state_d           = ST_SY;
				end
			end
			ST_SY: begin
				if (status.div_done) begin
					cmd.div_store     = 1'b1;
					cmd.div_store_sel = DIV_SY;
					state_d           = ST_ROUTE;
				end
			end
			ST_ROUTE: begin
				if (status.lone) begin
					state_d = ST_LAST;
				end else begin
					state_d = ST_PTS;
				end
			end
			// Capture the point count from the reciprocal multiply
			ST_PTS: begin
				cmd.div_store     = 1'b1;
				cmd.div_store_sel = DIV_PTS;
				state_d           = ST_PCHK;
			end
			ST_PCHK: begin
				if (status.pts_le1) begin
					state_d = ST_LAST;
				end else begin
					cmd.div_start     = 1'b1;
					cmd.div_start_sel = DIV_DX;
					state_d           = ST_DX;
				end
			end
			ST_DX: begin
				if (status.div_done) begin
					cmd.div_store     = 1'b1;
					cmd.div_store_sel = DIV_DX;
					cmd.div_start     = 1'b1;
					cmd.div_start_sel = DIV_DY;
					state_d           = ST_DY;
				end
			end
			ST_DY: begin
				if (status.div_done) begin
					cmd.div_store     = 1'b1;
					cmd.div_store_sel = DIV_DY;
					state_d           = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_step = 1'b1;
					if (status.step_final) begin
						state_d = ST_LAST;
					end
				end
			end
			ST_LAST: begin
				if (status.out_free) begin
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/ppi_checker.sv -----
// ----------------------------------------------------------------------------
// Path point interpolator checker
// Port-level checks on run ordering, output stalls and config ready, bound to the top level.
// ----------------------------------------------------------------------------
`include "path_point_interpolator_defines.svh"

module ppi_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ppi_pkg::COORD_W-1:0] out_x,
	input logic [ppi_pkg::COORD_W-1:0] out_y,
	input logic                        last_of_run,
	input logic                        cfg_valid,
	input logic                        cfg_ready
);
	import ppi_pkg::*;

	logic       in_fire, out_fire, run_done;
	logic [1:0] open_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign run_done = out_fire && last_of_run;

	// Count waypoints accepted whose final point has not yet transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 2'd0;
		end else if (in_fire && !run_done) begin
			open_q <= open_q + 2'd1;
		end else if (run_done && !in_fire && open_q != 2'd0) begin
			open_q <= open_q - 2'd1;
		end
	end

	// Hold a stalled point
	`PPI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(last_of_run))

	// One waypoint at a time: no accept in the cycle after an accept
	`PPI_ASSERT_NEXT(a_in_gap, clk, arst_n, in_fire, !in_ready)

	// Intermediate points only belong to an accepted waypoint
	`PPI_ASSERT_IMPL(a_mid_owned, clk, arst_n, out_fire && !last_of_run, open_q != 2'd0)

	// At most one earlier run may still be draining at an accept
	`PPI_ASSERT_IMPL(a_in_depth, clk, arst_n, in_fire, open_q != 2'd2 && open_q != 2'd3)

	// Configuration is never stalled
	`PPI_ASSERT_IMPL(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind path_point_interpolator ppi_checker u_ppi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (point_in.valid),
	.in_ready    (point_in.ready),
	.out_valid   (point_out.valid),
	.out_ready   (point_out.ready),
	.out_x       (point_out.out_x),
	.out_y       (point_out.out_y),
	.last_of_run (point_out.last_of_run),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);

// ----- bench/path_point_interpolator_checker.sv -----
// ----------------------------------------------------------------------------
// Path point interpolator checker
// Watches the register, waypoint and path point channels and keeps its own
// copy of the scaling registers and the previous waypoint. It works out the
// full run of points for every accepted waypoint and compares each accepted
// output transfer against the oldest point still due.
// ----------------------------------------------------------------------------
module path_point_interpolator_checker #(
	parameter int STEP_DIST = 8
) (
	input  logic clk,
	input  logic arst_n,
	ppi_cfg_if   cfg,
	ppi_in_if    point_in,
	ppi_out_if   point_out,
	output int   fail_cnt,
	output int   pending,
	output int   point_cnt
);
	import ppi_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} path_point_t;

	cfg_t               scale_cfg;
	logic [COORD_W-1:0] prev_x;
	logic [COORD_W-1:0] prev_y;
	logic               have_prev;
	path_point_t        due_points[$];
	path_point_t        got;
	path_point_t        want;
	int                 fails;
	int                 points_seen;

	// Scale one coordinate, truncating; saturate on overflow or a zero divisor
	function automatic logic [COORD_W-1:0] scaled_coord(input logic [COORD_W-1:0] c,
		input logic [COORD_W-1:0] num, input logic [COORD_W-1:0] den);
		logic [2*COORD_W-1:0] q;
		if (den == '0)
			return COORD_MAX;
		q = ({{COORD_W{1'b0}}, num} * {{COORD_W{1'b0}}, c}) / {{COORD_W{1'b0}}, den};
		return (q > COORD_MAX) ? COORD_MAX : q[COORD_W-1:0];
	endfunction

	// Queue every point that one waypoint produces and advance the history
	task automatic plan_run(input logic [COORD_W-1:0] raw_x, input logic [COORD_W-1:0] raw_y,
		input logic fresh);
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		int                 cur_x;
		int                 cur_y;
		int                 old_x;
		int                 old_y;
		int                 dx;
		int                 dy;
		int                 ax;
		int                 ay;
		int                 span;
		int                 pts;
		int                 j;
		path_point_t        p;
		px = raw_x;
		py = raw_y;
		if (scale_cfg.scale_enable) begin
			px = scaled_coord(raw_x, scale_cfg.x_num, scale_cfg.x_den);
			py = scaled_coord(raw_y, scale_cfg.y_num, scale_cfg.y_den);
		end
		if (!fresh && have_prev) begin
			cur_x = int'(px);
			cur_y = int'(py);
			old_x = int'(prev_x);
			old_y = int'(prev_y);
			dx = cur_x - old_x;
			dy = cur_y - old_y;
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			span = (ax > ay) ? ax : ay;
			pts = (span + STEP_DIST / 2) / STEP_DIST;
			for (j = 1; j < pts && j < 64; j++) begin
				p.x = COORD_W'(old_x + (j * dx) / pts);
				p.y = COORD_W'(old_y + (j * dy) / pts);
				p.last = 1'b0;
				due_points.push_back(p);
			end
		end
		p.x = px;
		p.y = py;
		p.last = 1'b1;
		due_points.push_back(p);
		prev_x = px;
		prev_y = py;
		have_prev = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_cfg.scale_enable = 1'b0;
			scale_cfg.x_num = 9'd1;
			scale_cfg.x_den = 9'd1;
			scale_cfg.y_num = 9'd1;
			scale_cfg.y_den = 9'd1;
			prev_x = '0;
			prev_y = '0;
			have_prev = 1'b0;
			due_points.delete();
			fails = 0;
			points_seen = 0;
			fail_cnt <= 0;
			pending <= 0;
			point_cnt <= 0;
		end else begin
			// Compare an output transfer with the oldest point due
			if (point_out.valid && point_out.ready) begin
				got.x = point_out.out_x;
				got.y = point_out.out_y;
				got.last = point_out.last_of_run;
				if (due_points.size() == 0) begin
					if (fails < 10)
						$display("unexpected path point x=%0d y=%0d last=%0d",
							got.x, got.y, got.last);
					fails++;
				end else begin
					want = due_points.pop_front();
					points_seen++;
					if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
						if (fails < 10)
							$display("path point %0d: expected x=%0d y=%0d last=%0d,",
								points_seen, want.x, want.y, want.last,
								" got x=%0d y=%0d last=%0d",
								got.x, got.y, got.last);
						fails++;
					end
				end
			end

			// Track register writes; unknown indexes are dropped
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SCALE_ENABLE: scale_cfg.scale_enable = cfg.data[0];
					REG_X_NUM:        scale_cfg.x_num = cfg.data;
					REG_X_DEN:        scale_cfg.x_den = cfg.data;
					REG_Y_NUM:        scale_cfg.y_num = cfg.data;
					REG_Y_DEN:        scale_cfg.y_den = cfg.data;
					default: ;
				endcase
			end

			if (point_in.valid && point_in.ready)
				plan_run(point_in.point_x, point_in.point_y, point_in.new_path);

			fail_cnt <= fails;
			pending <= due_points.size();
			point_cnt <= points_seen;
		end
	end

endmodule

// ----- bench/path_point_interpolator_tb.sv -----
// ----------------------------------------------------------------------------
// Path point interpolator testbench
// Drives waypoints and register writes into the block with random gaps and
// output back-pressure, including one long output stall; the checker beside
// the block and the assertion checker bound into it do the checking.
// ----------------------------------------------------------------------------
module path_point_interpolator_tb;
	import ppi_pkg::*;

	localparam int STEP_DIST   = 8;
	localparam int MAX_CYCLES  = 1000000;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 100;
	localparam int PHASE_ITEMS = 38;
	// Index outside the register map, written once to see it ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          fail_cnt;
	int          pending;
	int          point_cnt;
	int unsigned cycle_cnt = 0;
	bit          calm = 1'b0;
	bit          long_hold_req = 1'b0;
	int          n_items = 0;
	int          n_settings = 1;
	logic [COORD_W-1:0] last_x = '0;
	logic [COORD_W-1:0] last_y = '0;

	ppi_cfg_if cfg_ch ();
	ppi_in_if  in_ch ();
	ppi_out_if out_ch ();

	path_point_interpolator #(
		.STEP_DIST(STEP_DIST)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_ch),
		.point_in (in_ch),
		.point_out(out_ch)
	);

	path_point_interpolator_checker #(
		.STEP_DIST(STEP_DIST)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_ch),
		.point_in (in_ch),
		.point_out(out_ch),
		.fail_cnt (fail_cnt),
		.pending  (pending),
		.point_cnt(point_cnt)
	);

	always #5 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d points outstanding", cycle_cnt, pending);
			$display("path_point_interpolator_tb NOT OK");
			$finish;
		end
	end

	// Offer one waypoint, maybe after an idle burst; hold valid until the transfer
	task automatic offer_waypoint(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic fresh);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.point_x <= x;
		in_ch.point_y <= y;
		in_ch.new_path <= fresh;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		last_x = x;
		last_y = y;
		n_items++;
	endtask

	// Drop valid and wait until every point due has been taken
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// One register write transfer; valid stays up for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic apply_setting(input logic en, input logic [COORD_W-1:0] xn,
		input logic [COORD_W-1:0] xd, input logic [COORD_W-1:0] yn,
		input logic [COORD_W-1:0] yd);
		write_reg(REG_SCALE_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
		write_reg(REG_X_NUM, xn);
		write_reg(REG_X_DEN, xd);
		write_reg(REG_Y_NUM, yn);
		write_reg(REG_Y_DEN, yd);
		cfg_ch.valid <= 1'b0;
		n_settings++;
	endtask

	// Output back-pressure: random bursts, one long hold on request, none when calm
	initial begin : sink_ready
		out_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int   ph;
		int   k;
		int   hx;
		int   hy;
		logic fresh;
		in_ch.valid <= 1'b0;
		in_ch.point_x <= '0;
		in_ch.point_y <= '0;
		in_ch.new_path <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset registers: no scaling
		offer_waypoint(9'd0, 9'd0, 1'b0);       // no history yet: emitted alone
		offer_waypoint(9'd511, 9'd511, 1'b0);   // longest diagonal
		offer_waypoint(9'd0, 9'd0, 1'b0);       // longest run backwards
		offer_waypoint(9'd3, 9'd3, 1'b0);       // too short for any step
		offer_waypoint(9'd7, 9'd0, 1'b0);       // exactly one step
		offer_waypoint(9'd20, 9'd511, 1'b0);    // vertical distance dominates
		offer_waypoint(9'd300, 9'd100, 1'b1);   // new path
		offer_waypoint(9'h155, 9'h0AA, 1'b0);
		offer_waypoint(9'h0AA, 9'h155, 1'b0);
		offer_waypoint(9'd12, 9'd340, 1'b0);    // both coordinates decrease
		settle();

		// Overflow on x, heavy shrink on y
		apply_setting(1'b1, 9'd511, 9'd1, 9'd1, 9'd511);
		offer_waypoint(9'd0, 9'd0, 1'b1);
		offer_waypoint(9'd1, 9'd511, 1'b0);
		offer_waypoint(9'd511, 9'd0, 1'b0);
		offer_waypoint(9'd2, 9'd256, 1'b0);
		settle();

		// Zero divisor on x; write to an unmapped index first
		write_reg(REG_UNUSED, 9'h1FF);
		apply_setting(1'b1, 9'd511, 9'd0, 9'd511, 9'd2);
		offer_waypoint(9'd5, 9'd5, 1'b1);
		offer_waypoint(9'd0, 9'd1, 1'b0);
		offer_waypoint(9'd100, 9'd3, 1'b0);
		offer_waypoint(9'd511, 9'd511, 1'b0);
		settle();

		// Random phases, each under its own register setting
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					apply_setting(1'b0, COORD_W'($urandom_range(1, 511)),
						COORD_W'($urandom_range(1, 511)),
						COORD_W'($urandom_range(1, 511)),
						COORD_W'($urandom_range(1, 511)));
					long_hold_req = 1'b1;
				end
				1: begin
					apply_setting(1'b1, COORD_W'($urandom_range(1, 511)),
						COORD_W'($urandom_range(1, 511)),
						COORD_W'($urandom_range(1, 511)),
						COORD_W'($urandom_range(1, 511)));
				end
				2: begin
					apply_setting(1'b1, 9'd511, 9'd511, 9'd1, 9'd1);
				end
				default: begin
					apply_setting(1'($urandom_range(0, 1)),
						COORD_W'($urandom_range(1, 511)),
						COORD_W'($urandom_range(1, 511)),
						COORD_W'($urandom_range(1, 511)),
						COORD_W'($urandom_range(1, 511)));
					calm = 1'b1;
				end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				fresh = ($urandom_range(0, 9) == 0);
				if ($urandom_range(0, 3) == 0) begin
					// short hop near the last waypoint
					hx = int'(last_x);
					hy = int'(last_y);
					hx = hx + int'($urandom_range(0, 12));
					hy = hy + int'($urandom_range(0, 12));
					hx = hx - 6;
					hy = hy - 6;
					if (hx < 0) hx = 0;
					if (hy < 0) hy = 0;
					if (hx > 511) hx = 511;
					if (hy > 511) hy = 511;
				end else begin
					hx = int'($urandom_range(0, 511));
					hy = int'($urandom_range(0, 511));
				end
				offer_waypoint(hx[COORD_W-1:0], hy[COORD_W-1:0], fresh);
			end
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d waypoints under %0d register settings, %0d path points compared",
			n_items, n_settings, point_cnt);
		$display("%0d mismatches, %0d points still outstanding", fail_cnt, pending);
		if (fail_cnt == 0 && pending == 0)
			$display("path_point_interpolator_tb OK");
		else
			$display("path_point_interpolator_tb NOT OK");
		$finish;
	end

endmodule
